@@ hw/rtl/cidv_pkg.sv @@
// ----------------------------------------------------------------------------
// cidv_pkg
// Shared types, codes and tables for the citizen ID check-digit validator.
// ----------------------------------------------------------------------------
package cidv_pkg;

  // Configuration register indexes
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  localparam logic [11:0] MIN_YEAR_RST = 12'd1921;
  localparam logic [11:0] MAX_YEAR_RST = 12'd2021;

  localparam int unsigned NumDigits = 13;

  // Result codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_DIGIT = 2'd1,
    ERR_DATE  = 2'd2,
    ERR_CHECK = 2'd3
  } err_e;

  // Fields decoded from one ID number in the first stage
  typedef struct packed {
    logic       bad_digit;
    logic [6:0] day;
    logic [6:0] month;
    logic [11:0] year;
    logic [6:0] region;
    logic       female;
    logic       leap;
    logic [8:0] wsum;
    logic [3:0] chk_digit;
  } dec_t;

  // Days in a month for a non-leap year; month codes outside 1..12 give 0
  function automatic logic [4:0] month_days(input logic [6:0] month);
    logic [4:0] days;
    case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    days = 5'd30;
      7'd2:                                       days = 5'd28;
      default:                                    days = 5'd0;
    endcase
    return days;
  endfunction

endpackage

@@ hw/rtl/cidv_decode.sv @@
// ----------------------------------------------------------------------------
// cidv_decode
// Splits the packed BCD number into digits, flags non-decimal nibbles,
// builds day, month, year, region and sex fields, the leap-year flag and
// the weighted digit-pair sum for the mod-11 check.
// ----------------------------------------------------------------------------
module cidv_decode (
  input  logic [51:0]         id_digits_i,
  output cidv_pkg::dec_t      dec_o
);

  logic [3:0] dg [cidv_pkg::NumDigits];
  logic       bad;
  logic [4:0] pair [6];
  logic [8:0] wsum;
  logic [9:0] ylow;
  logic       div100;
  logic       div400;

  // Unpack digits, most significant first
  always_comb begin
    bad = 1'b0;
    for (int k = 0; k < cidv_pkg::NumDigits; k++) begin
      dg[k] = id_digits_i[(cidv_pkg::NumDigits - 1 - k) * 4 +: 4];
      if (dg[k] > 4'd9) begin
        bad = 1'b1;
      end
    end
  end

  // Weighted sum of digit pairs, weights 7 down to 2
  always_comb begin
    wsum = '0;
    for (int k = 0; k < 6; k++) begin
      pair[k] = {1'b0, dg[k]} + {1'b0, dg[k + 6]};
      wsum    = wsum + 9'(pair[k] * 4'(7 - k));
    end
  end

  // Year: three digits below 100 land in the 2000s, otherwise 1000 + y
  assign ylow   = 10'(dg[4] * 7'd100) + 10'(dg[5] * 4'd10) + {6'd0, dg[6]};
  assign div100 = (dg[5] == 4'd0) && (dg[6] == 4'd0);
  // Century 20, 12 or 16 is a multiple of four
  assign div400 = div100 && ((dg[4] == 4'd0) || (dg[4] == 4'd2) || (dg[4] == 4'd6));

  always_comb begin
    dec_o.bad_digit = bad;
    dec_o.day       = 7'(dg[0] * 4'd10) + {3'd0, dg[1]};
    dec_o.month     = 7'(dg[2] * 4'd10) + {3'd0, dg[3]};
    dec_o.year      = {2'd0, ylow} + ((dg[4] == 4'd0) ? 12'd2000 : 12'd1000);
    dec_o.region    = 7'(dg[7] * 4'd10) + {3'd0, dg[8]};
    dec_o.female    = (dg[9] >= 4'd5);
    dec_o.leap      = ((ylow[1:0] == 2'b00) && !div100) || div400;
    dec_o.wsum      = wsum;
    dec_o.chk_digit = dg[12];
  end

endmodule

@@ hw/rtl/citizen_id_check_digit_validator.sv @@
// ----------------------------------------------------------------------------
// citizen_id_check_digit_validator
// Validates a 13-digit citizen ID given as packed BCD: decimal digits, a real
// date within the configured year bounds, and the mod-11 check digit.
// ----------------------------------------------------------------------------
// The block takes one ID per clock cycle while in_ready_o is high, through
// three register stages: digit decode and weighted sum, mod-11 remainder and
// date check, then check-digit compare into the output register. Stages
// advance together with the output side; when the output is stalled, each
// stage holds only while the one below it is full; bubbles are squeezed out
// and input is accepted until all are full. The user must write year bounds
// via the configuration port only while no ID is in flight; not enforced.
// ----------------------------------------------------------------------------
module citizen_id_check_digit_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [51:0] id_digits_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        id_valid_o,
  output logic [1:0]  error_code_o,
  output logic [6:0]  birth_day_o,
  output logic [6:0]  birth_month_o,
  output logic [11:0] birth_year_o,
  output logic [6:0]  region_code_o,
  output logic        is_female_o,
  output logic [3:0]  expected_check_o
);

  logic [11:0] min_year_q, max_year_q;

  cidv_pkg::dec_t dec;
  logic           v1_q, v2_q, v3_q;
  logic           en1, en2, en3;
  cidv_pkg::dec_t s1_q;

  // stage 2 payload
  logic        s2_bad_q;
  logic [6:0]  s2_day_q, s2_month_q, s2_region_q;
  logic [11:0] s2_year_q;
  logic        s2_female_q;
  logic [3:0]  s2_rem_q, s2_rem_d;
  logic        s2_date_ok_q, s2_date_ok_d;
  logic [3:0]  s2_chk_digit_q;

  // stage 3 (output) payload
  logic        s3_valid_d, s3_valid_q;
  logic [1:0]  s3_err_d, s3_err_q;
  logic [6:0]  s3_day_q, s3_month_q, s3_region_q;
  logic [11:0] s3_year_q;
  logic        s3_female_q;
  logic [3:0]  s3_chk_d, s3_chk_q;

  logic [17:0] quot_prod;
  logic [5:0]  quot;
  logic [8:0]  rem_full;
  logic [4:0]  day_lim;

  // Hold year bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= cidv_pkg::MIN_YEAR_RST;
      max_year_q <= cidv_pkg::MAX_YEAR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cidv_pkg::CFG_MIN_YEAR) begin
        min_year_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == cidv_pkg::CFG_MAX_YEAR) begin
        max_year_q <= cfg_wdata_i;
      end
    end
  end

  // Advance a stage when it is empty or the next one moves
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: decode
  cidv_decode u_decode (
    .id_digits_i (id_digits_i),
    .dec_o       (dec)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= dec;
    end
  end

  // Stage 2: remainder by reciprocal (exact for sums up to 486), date check
  assign quot_prod = {9'd0, s1_q.wsum} * 18'd373;
  assign quot      = quot_prod[17:12];
  assign rem_full  = s1_q.wsum - 9'(quot * 4'd11);
  assign s2_rem_d  = rem_full[3:0];

  assign day_lim = cidv_pkg::month_days(s1_q.month)
                 + {4'd0, (s1_q.month == 7'd2) && s1_q.leap};

  assign s2_date_ok_d = (s1_q.month >= 7'd1) && (s1_q.month <= 7'd12)
                      && (s1_q.year >= min_year_q) && (s1_q.year <= max_year_q)
                      && (s1_q.day >= 7'd1) && (s1_q.day <= {2'd0, day_lim});

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_bad_q       <= s1_q.bad_digit;
      s2_day_q       <= s1_q.day;
      s2_month_q     <= s1_q.month;
      s2_year_q      <= s1_q.year;
      s2_region_q    <= s1_q.region;
      s2_female_q    <= s1_q.female;
      s2_rem_q       <= s2_rem_d;
      s2_date_ok_q   <= s2_date_ok_d;
      s2_chk_digit_q <= s1_q.chk_digit;
    end
  end

  // Stage 3: check digit and result code
  assign s3_chk_d = (s2_rem_q == 4'd0) ? 4'd0 : 4'd11 - s2_rem_q;

  always_comb begin
    s3_valid_d = 1'b0;
    if (s2_bad_q) begin
      s3_err_d = cidv_pkg::ERR_DIGIT;
    end else if (!s2_date_ok_q) begin
      s3_err_d = cidv_pkg::ERR_DATE;
    end else if (s3_chk_d != s2_chk_digit_q) begin
      s3_err_d = cidv_pkg::ERR_CHECK;
    end else begin
      s3_err_d   = cidv_pkg::ERR_OK;
      s3_valid_d = 1'b1;
    end
  end

  // Register the result; drop decoded fields when a digit is not decimal
  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_valid_q  <= s3_valid_d;
      s3_err_q    <= s3_err_d;
      s3_day_q    <= s2_bad_q ? 7'd0  : s2_day_q;
      s3_month_q  <= s2_bad_q ? 7'd0  : s2_month_q;
      s3_year_q   <= s2_bad_q ? 12'd0 : s2_year_q;
      s3_region_q <= s2_bad_q ? 7'd0  : s2_region_q;
      s3_female_q <= s2_bad_q ? 1'b0  : s2_female_q;
      s3_chk_q    <= s2_bad_q ? 4'd0  : s3_chk_d;
    end
  end

  assign out_valid_o      = v3_q;
  assign id_valid_o       = s3_valid_q;
  assign error_code_o     = s3_err_q;
  assign birth_day_o      = s3_day_q;
  assign birth_month_o    = s3_month_q;
  assign birth_year_o     = s3_year_q;
  assign region_code_o    = s3_region_q;
  assign is_female_o      = s3_female_q;
  assign expected_check_o = s3_chk_q;

endmodule
